// ===== src/mca_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mca_pkg
// Shared constants, types and helpers of the moving or cumulative average.
// ----------------------------------------------------------------------------
package mca_pkg;

   localparam int HIST_DEPTH = 256;
   localparam int HIST_AW    = $clog2(HIST_DEPTH);
   localparam int LEN_W      = $clog2(HIST_DEPTH + 1);
   localparam int TOT_W      = 32 + HIST_AW;
   localparam int WIN_W      = 9;
   localparam int DIV_W      = 64;
   localparam int DVS_W      = 33;
   localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

   localparam logic signed [WIN_W-1:0] WIN_RESET = 9'sd10;
   localparam logic [31:0]             COUNT_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic signed [31:0] sample;
      logic               sample_valid;
      logic               clear;
   } item_type;

   typedef struct packed {
      logic                    start;
      logic signed [DIV_W-1:0] dividend;
      logic [DVS_W-1:0]        divisor;
   } div_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [DIV_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CONV,
      ST_FILL,
      ST_AVG_DIV,
      ST_SAMPLE,
      ST_CUM_MUL,
      ST_CUM_DIV,
      ST_MOV_START,
      ST_MOV_DIV,
      ST_TRIM,
      ST_TRIM_UPD
   } back_state_type;

   // effective window: negative gives zero, capped at depth - 1
   function automatic logic [LEN_W-1:0] cap_window(input logic signed [WIN_W-1:0] w);
      logic [LEN_W-1:0] r;
      if (w < 0) begin
         r = '0;
      end else if (int'(w) > HIST_DEPTH - 1) begin
         r = LEN_W'(HIST_DEPTH - 1);
      end else begin
         r = LEN_W'($unsigned(w));
      end
      return r;
   endfunction

   function automatic logic [HIST_AW-1:0] wrap_slot(input logic [HIST_AW-1:0] base,
                                                   input logic [LEN_W-1:0] ofs);
      logic [LEN_W:0] s;
      s = (LEN_W+1)'(base) + (LEN_W+1)'(ofs);
      if (s >= (LEN_W+1)'(HIST_DEPTH)) begin
         s = s - (LEN_W+1)'(HIST_DEPTH);
      end
      return HIST_AW'(s);
   endfunction

   function automatic logic [HIST_AW-1:0] next_slot(input logic [HIST_AW-1:0] base);
      logic [HIST_AW-1:0] r;
      if (base == HIST_AW'(HIST_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = base + 1'b1;
      end
      return r;
   endfunction

endpackage

// ===== src/mca_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mca_front
// Accepts input transactions into a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module mca_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mca_pkg::item_type req_item,
   output logic              item_valid,
   output mca_pkg::item_type item,
   input  logic              item_pop
);
   import mca_pkg::*;

   item_type   fifo_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   logic       pop;

   assign req_stall  = (cnt_ff == 2'd2);
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = fifo_ff[rd_ptr_ff];
   assign push       = req_valid && !req_stall;
   assign pop        = item_pop && item_valid;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

// ===== src/mca_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mca_div
// Signed by positive restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mca_div (
   input  logic                 clock,
   input  logic                 reset,
   input  mca_pkg::div_req_type req,
   output mca_pkg::div_rsp_type rsp
);
   import mca_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W:0]       rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DVS_W-1:0]     dvs_ff, dvs_in;
   logic                 neg_ff, neg_in;
   logic [DVS_W:0]       shifted;
   logic [DVS_W+1:0]     diff;

   assign shifted = {rem_ff[DVS_W-1:0], quo_ff[DIV_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_W);
         rem_in  = '0;
         quo_in  = req.dividend[DIV_W-1] ? $unsigned(-req.dividend) : $unsigned(req.dividend);
         dvs_in  = req.divisor;
         neg_in  = req.dividend[DIV_W-1];
      end else if (busy_ff) begin
         rem_in = diff[DVS_W+1] ? shifted : diff[DVS_W:0];
         quo_in = {quo_ff[DIV_W-2:0], !diff[DVS_W+1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

// ===== src/mca_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mca_back
// Sequencer: clear, window conversion, averaging and history ring buffer.
// ----------------------------------------------------------------------------
module mca_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             item_valid,
   input  mca_pkg::item_type                item,
   output logic                             item_pop,
   input  logic signed [mca_pkg::WIN_W-1:0] win,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [31:0]               rsp_mean_value,
   output mca_pkg::div_req_type             div_req,
   input  mca_pkg::div_rsp_type             div_rsp
);
   import mca_pkg::*;

   back_state_type          state_ff, state_in;
   item_type                item_ff, item_in;
   logic signed [WIN_W-1:0] prev_ff, prev_in;
   logic signed [31:0]      held_ff, held_in;
   logic [31:0]             count_ff, count_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic [HIST_AW-1:0]      oldest_ff, oldest_in;
   logic signed [TOT_W-1:0] total_ff, total_in;
   logic [LEN_W-1:0]        fill_n_ff, fill_n_in;
   logic                    post_ff, post_in;
   logic signed [31:0]      mean_ff, mean_in;
   logic signed [63:0]      prod_ff, prod_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]      rsp_mean_ff, rsp_mean_in;

   logic signed [31:0]      mem [HIST_DEPTH];
   logic signed [31:0]      rd_data_ff;
   logic                    mem_we;
   logic [HIST_AW-1:0]      mem_wa;
   logic signed [31:0]      mem_wd;
   logic                    mem_re;

   logic [LEN_W-1:0]        cap;
   logic [31:0]             c_val;
   logic signed [64:0]      prod_full;
   logic signed [63:0]      total_x;

   assign cap       = cap_window(win);
   assign c_val     = (count_ff == COUNT_MAX) ? COUNT_MAX - 32'd1 : count_ff;
   assign prod_full = held_ff * $signed({1'b0, c_val});
   assign total_x   = {{(64-TOT_W){total_ff[TOT_W-1]}}, total_ff};

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mean_value = rsp_mean_ff;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      prev_in      = prev_ff;
      held_in      = held_ff;
      count_in     = count_ff;
      len_in       = len_ff;
      oldest_in    = oldest_ff;
      total_in     = total_ff;
      fill_n_in    = fill_n_ff;
      post_in      = post_ff;
      mean_in      = mean_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_mean_in  = rsp_mean_ff;
      item_pop     = 1'b0;
      mem_we       = 1'b0;
      mem_wa       = '0;
      mem_wd       = held_ff;
      mem_re       = 1'b0;
      div_req      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid && (!rsp_valid_ff || !rsp_stall)) begin
               item_pop = 1'b1;
               item_in  = item;
               if (item.clear) begin
                  prev_in   = '0;
                  count_in  = '0;
                  len_in    = '0;
                  oldest_in = '0;
                  total_in  = '0;
               end
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            state_in = ST_SAMPLE;
            if (prev_ff != win) begin
               prev_in = win;
               if (prev_ff[WIN_W-1] && !win[WIN_W-1]) begin
                  // cumulative to moving: refill with the held average
                  fill_n_in = (count_ff < 32'(cap)) ? LEN_W'(count_ff) : cap;
                  len_in    = '0;
                  oldest_in = '0;
                  total_in  = '0;
                  count_in  = '0;
                  state_in  = ST_FILL;
               end else if (!prev_ff[WIN_W-1] && win[WIN_W-1]) begin
                  if (len_ff == '0) begin
                     held_in   = '0;
                     count_in  = '0;
                     oldest_in = '0;
                     total_in  = '0;
                  end else begin
                     div_req.start    = 1'b1;
                     div_req.dividend = total_x;
                     div_req.divisor  = DVS_W'(len_ff);
                     state_in         = ST_AVG_DIV;
                  end
               end else if (prev_ff > win && !win[WIN_W-1]) begin
                  post_in  = 1'b0;
                  state_in = ST_TRIM;
               end
            end
         end
         ST_FILL: begin
            if (len_ff < fill_n_ff) begin
               mem_we   = 1'b1;
               mem_wa   = HIST_AW'(len_ff);
               mem_wd   = held_ff;
               len_in   = len_ff + 1'b1;
               total_in = total_ff + TOT_W'(held_ff);
            end else begin
               state_in = ST_SAMPLE;
            end
         end
         ST_AVG_DIV: begin
            if (div_rsp.done) begin
               held_in   = div_rsp.quotient[31:0];
               count_in  = 32'(len_ff);
               len_in    = '0;
               oldest_in = '0;
               total_in  = '0;
               state_in  = ST_SAMPLE;
            end
         end
         ST_SAMPLE: begin
            if (!item_ff.sample_valid) begin
               state_in = ST_IDLE;
            end else if (win[WIN_W-1]) begin
               if (count_ff == '0) begin
                  held_in      = item_ff.sample;
                  count_in     = 32'd1;
                  rsp_valid_in = 1'b1;
                  rsp_mean_in  = item_ff.sample;
                  state_in     = ST_IDLE;
               end else begin
                  prod_in  = prod_full[63:0];
                  state_in = ST_CUM_MUL;
               end
            end else begin
               mem_we   = 1'b1;
               mem_wa   = wrap_slot(oldest_ff, len_ff);
               mem_wd   = item_ff.sample;
               len_in   = len_ff + 1'b1;
               total_in = total_ff + TOT_W'(item_ff.sample);
               state_in = ST_MOV_START;
            end
         end
         ST_CUM_MUL: begin
            div_req.start    = 1'b1;
            div_req.dividend = prod_ff + 64'(item_ff.sample);
            div_req.divisor  = {1'b0, c_val} + 33'd1;
            state_in         = ST_CUM_DIV;
         end
         ST_CUM_DIV: begin
            if (div_rsp.done) begin
               held_in      = div_rsp.quotient[31:0];
               rsp_valid_in = 1'b1;
               rsp_mean_in  = div_rsp.quotient[31:0];
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + 32'd1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_MOV_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = total_x;
            div_req.divisor  = DVS_W'(len_ff);
            state_in         = ST_MOV_DIV;
         end
         ST_MOV_DIV: begin
            if (div_rsp.done) begin
               mean_in  = div_rsp.quotient[31:0];
               post_in  = 1'b1;
               state_in = ST_TRIM;
            end
         end
         ST_TRIM: begin
            if (len_ff > cap) begin
               mem_re   = 1'b1;
               state_in = ST_TRIM_UPD;
            end else if (post_ff) begin
               rsp_valid_in = 1'b1;
               rsp_mean_in  = mean_ff;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_SAMPLE;
            end
         end
         ST_TRIM_UPD: begin
            total_in  = total_ff - TOT_W'(rd_data_ff);
            oldest_in = next_slot(oldest_ff);
            len_in    = len_ff - 1'b1;
            state_in  = ST_TRIM;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_ff      <= '0;
         held_ff      <= '0;
         count_ff     <= '0;
         len_ff       <= '0;
         oldest_ff    <= '0;
         total_ff     <= '0;
         post_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         held_ff      <= held_in;
         count_ff     <= count_in;
         len_ff       <= len_in;
         oldest_ff    <= oldest_in;
         total_ff     <= total_in;
         post_ff      <= post_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      fill_n_ff   <= fill_n_in;
      mean_ff     <= mean_in;
      prod_ff     <= prod_in;
      rsp_mean_ff <= rsp_mean_in;
   end

   // history ring buffer
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[oldest_ff];
      end
   end

endmodule

// ===== src/moving_or_cumulative_average.sv =====
`timescale 1ns / 1ps
// A sample transaction's result, but for the first cumulative one, comes from the
// 64-step shift-subtract divider; a window change may first fill or drop history
// entries. The back end handles one transaction at a time and takes no new one
// until it is through with the last; a two-entry queue takes input meanwhile.
// Reset: synchronous, clears queue, state and output; window register returns to 10.
// ----------------------------------------------------------------------------
// moving_or_cumulative_average
// Moving or cumulative average of signed Q16.16 samples.
// ----------------------------------------------------------------------------
module moving_or_cumulative_average (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [31:0]               req_sample,
   input  logic                             req_sample_valid,
   input  logic                             req_clear,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [31:0]               rsp_mean_value,
   input  logic                             csr_wr_en,
   input  logic signed [mca_pkg::WIN_W-1:0] csr_wr_data
);
   import mca_pkg::*;

   logic signed [WIN_W-1:0] win_ff, win_in;
   item_type                req_item;
   item_type                item;
   logic                    item_valid;
   logic                    item_pop;
   div_req_type             div_req;
   div_rsp_type             div_rsp;

   assign req_item.sample       = req_sample;
   assign req_item.sample_valid = req_sample_valid;
   assign req_item.clear        = req_clear;
   assign win_in                = csr_wr_en ? csr_wr_data : win_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= WIN_RESET;
      end else begin
         win_ff <= win_in;
      end
   end

   mca_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   mca_back u_back (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (item_valid),
      .item           (item),
      .item_pop       (item_pop),
      .win            (win_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_mean_value (rsp_mean_value),
      .div_req        (div_req),
      .div_rsp        (div_rsp)
   );

   mca_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

endmodule

// ===== src/mca_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mca_checker
// Port-level checks of the average block, bound to the top level.
// ----------------------------------------------------------------------------
module mca_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_mean_value
);

   // a stalled result transaction stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_mean_value))
      else $error("stalled result changed");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("outputs not cleared by reset");

   // a result needs a queue stage and sequencer steps after reset
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(reset, 2))
      else $error("result too soon after reset");

endmodule

bind moving_or_cumulative_average mca_checker u_mca_checker (.*);
